// ===== rtl/pwa_pkg.sv =====
// shared types, widths and codes of the pulse width apodizer
`default_nettype none

package pwa_pkg;

   // column size and derived widths
   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int POS_W       = $clog2(MAX_SAMPLES + 1);

   // field widths
   localparam int CMD_W    = 2;
   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 10;
   localparam int OUT_W    = 2;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 1;

   // arithmetic widths
   localparam int MAG_W      = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int ACC_W      = PROD_W + CFG_W + 1;
   localparam int ENERGY_W   = 32;
   localparam int DPROD_W    = CFG_W + ENERGY_W;
   localparam int TERM_SHIFT = 31;
   localparam int TERM_W     = ACC_W - TERM_SHIFT;
   localparam int WIDTH_SHIFT = 30;
   localparam int WRAW_W     = DPROD_W + 1 - WIDTH_SHIFT;
   localparam int HALF_W     = ENERGY_W / 2;

   // rounding constant for the width product
   localparam logic [DPROD_W:0] ROUND_HALF = (DPROD_W + 1)'(64'd1 << (WIDTH_SHIFT - 1));

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY   = 1'b1;
   localparam logic [CFG_W-1:0] WEIGHT_RESET = 16'd32768;
   localparam logic [CFG_W-1:0] DUTY_RESET   = 16'd16384;

   // trinary codes, also the pulse sign
   localparam logic [OUT_W-1:0] SIGN_NONE = 2'b00;
   localparam logic [OUT_W-1:0] SIGN_POS  = 2'b01;
   localparam logic [OUT_W-1:0] SIGN_NEG  = 2'b11;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_E0,
      ST_E1,
      ST_E2,
      ST_E3,
      ST_E4,
      ST_W0,
      ST_W1,
      ST_W2,
      ST_W3,
      ST_W4,
      ST_W5,
      ST_FILL,
      ST_COMMIT,
      ST_READ_OUT
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_16,
      SH_17
   } shift_type;

   typedef struct packed {
      acc_op_type acc_op;
      shift_type  shift;
   } mul_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/pwa_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module pwa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pwa_mul_unit.sv =====
// shared 17x17 multiplier with registered product and shifting accumulator
`default_nettype none

module pwa_mul_unit import pwa_pkg::*; (
   input  wire logic              clock,
   input  wire mul_ctl_type       ctl,
   input  wire logic [MAG_W-1:0]  op_a,
   input  wire logic [MAG_W-1:0]  op_b,
   output logic      [PROD_W-1:0] prod,
   output logic      [ACC_W-1:0]  acc
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [ACC_W-1:0]  prod_ext;
   logic [ACC_W-1:0]  shifted;

   // product of the current operands
   assign prod_in  = PROD_W'(op_a * op_b);
   assign prod_ext = ACC_W'(prod_ff);

   // align the previous product
   always_comb begin
      case (ctl.shift)
         SH_0:    shifted = prod_ext;
         SH_16:   shifted = prod_ext << 16;
         SH_17:   shifted = prod_ext << 17;
         default: shifted = prod_ext;
      endcase
   end

   // accumulator update
   always_comb begin
      case (ctl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = shifted;
         ACC_ADD:  acc_in = acc_ff + shifted;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/pulse_width_apodizer_top.sv =====
// Pulse width apodizer: turns one element's pushed waveform into trinary pulses.
// A request is taken on a clock edge with start high and busy low; busy stays high
// until the request is done. A read returns its value on rsp_out_value with rsp_valid
// high for one cycle, in ST_READ_OUT after the memory read of ST_DECODE; the receiver
// cannot stall it. States per request: read ST_DECODE, ST_READ_OUT; unused command or
// push into a full column ST_DECODE alone; finish with no open pulse, or push that
// opens a pulse or continues nothing, ST_DECODE, ST_COMMIT; push inside a pulse adds
// ST_E0-E4 (a 17x17 multiplier shared for square, weight and duty products); a request
// ending a pulse adds ST_W0-W5, then ST_FILL for a nonzero width, as memory takes one write per cycle.
// Registers may be written only while busy is low.
`default_nettype none

module pulse_width_apodizer_top import pwa_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic        [CMD_W-1:0]     req_cmd,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_value,
   input  wire logic        [IDX_W-1:0]     req_read_index,
   output logic                             rsp_valid,
   output logic signed      [OUT_W-1:0]     rsp_out_value,
   input  wire logic                        csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [CFG_W-1:0]     csr_wdata
);

   // control and architectural state
   state_type           state_ff, state_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [OUT_W-1:0]    sign_ff, sign_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [CFG_W-1:0]    weight_ff, weight_in;
   logic [CFG_W-1:0]    duty_ff, duty_in;

   // request and working registers
   cmd_type             cmd_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [MAG_W-1:0]    sq_hi_ff, sq_hi_in;
   logic [WRAW_W-1:0]   wraw_ff, wraw_in;
   logic [POS_W-1:0]    span_ff, span_in;
   logic [POS_W-1:0]    width_ff, width_in;
   logic [ADDR_W-1:0]   fill_addr_ff, fill_addr_in;
   logic [POS_W-1:0]    fill_cnt_ff, fill_cnt_in;

   // datapath helpers
   logic                accept;
   logic                full;
   logic [OUT_W-1:0]    sgn_now;
   logic [MAG_W-1:0]    sum;
   logic [ENERGY_W:0]   energy_sum;
   logic [DPROD_W:0]    round_sum;
   logic [POS_W-1:0]    gap;
   logic [POS_W-1:0]    first;
   logic                rd_oor;

   // memory and multiplier hookup
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [OUT_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [OUT_W-1:0]    ram_rdata;
   mul_ctl_type         mul_ctl;
   logic [MAG_W-1:0]    mul_a;
   logic [MAG_W-1:0]    mul_b;
   logic [PROD_W-1:0]   mul_prod;
   logic [ACC_W-1:0]    mul_acc;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (position_ff >= POS_W'(MAX_SAMPLES));
   assign rd_oor = ({1'b0, idx_ff} >= (IDX_W + 1)'(MAX_SAMPLES));

   // sign of the pushed sample
   always_comb begin
      if (sample_ff == '0) begin
         sgn_now = SIGN_NONE;
      end else if (sample_ff[SAMPLE_W-1]) begin
         sgn_now = SIGN_NEG;
      end else begin
         sgn_now = SIGN_POS;
      end
   end

   // sign-extended sum of previous and current sample
   assign sum = {prev_ff[SAMPLE_W-1], prev_ff} + {sample_ff[SAMPLE_W-1], sample_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_PUSH: begin
                  if (full) begin
                     state_in = ST_IDLE;
                  end else if (sgn_now == SIGN_NONE) begin
                     state_in = (sign_ff != SIGN_NONE) ? ST_W0 : ST_COMMIT;
                  end else if (sign_ff == SIGN_NONE) begin
                     state_in = ST_COMMIT;
                  end else if (sign_ff != sgn_now) begin
                     state_in = ST_W0;
                  end else begin
                     state_in = ST_E0;
                  end
               end
               CMD_FINISH: state_in = (sign_ff != SIGN_NONE) ? ST_W0 : ST_COMMIT;
               CMD_READ:   state_in = ST_READ_OUT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_E0:       state_in = ST_E1;
         ST_E1:       state_in = ST_E2;
         ST_E2:       state_in = ST_E3;
         ST_E3:       state_in = ST_E4;
         ST_E4:       state_in = ST_COMMIT;
         ST_W0:       state_in = ST_W1;
         ST_W1:       state_in = ST_W2;
         ST_W2:       state_in = ST_W3;
         ST_W3:       state_in = ST_W4;
         ST_W4:       state_in = ST_W5;
         ST_W5:       state_in = (width_ff != '0) ? ST_FILL : ST_COMMIT;
         ST_FILL:     state_in = (fill_cnt_ff == POS_W'(1)) ? ST_COMMIT : ST_FILL;
         ST_COMMIT:   state_in = ST_IDLE;
         ST_READ_OUT: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath, memory and multiplier controls
   always_comb begin
      position_in  = position_ff;
      start_in     = start_ff;
      sign_in      = sign_ff;
      prev_in      = prev_ff;
      energy_in    = energy_ff;
      mag_in       = mag_ff;
      sq_hi_in     = sq_hi_ff;
      wraw_in      = wraw_ff;
      span_in      = span_ff;
      width_in     = width_ff;
      fill_addr_in = fill_addr_ff;
      fill_cnt_in  = fill_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = fill_addr_ff;
      ram_wdata    = sign_ff;
      ram_re       = 1'b0;
      ram_raddr    = ADDR_W'(idx_ff);
      mul_ctl      = '{acc_op: ACC_HOLD, shift: SH_0};
      mul_a        = mag_ff;
      mul_b        = mag_ff;
      energy_sum   = {1'b0, energy_ff} + (ENERGY_W + 1)'(mul_acc[ACC_W-1:TERM_SHIFT]);
      round_sum    = {1'b0, mul_acc[DPROD_W-1:0]} + ROUND_HALF;
      gap          = (span_ff - width_ff) >> 1;
      first        = POS_W'(start_ff) + gap;
      rsp_valid    = 1'b0;
      rsp_out_value = '0;

      case (state_ff)
         ST_DECODE: begin
            // clear own position on push if not full, start the read on read
            if (cmd_ff == CMD_PUSH && !full) begin
               ram_we    = 1'b1;
               ram_waddr = position_ff[ADDR_W-1:0];
               ram_wdata = SIGN_NONE;
            end
            if (cmd_ff == CMD_READ) begin
               ram_re = 1'b1;
            end
            mag_in = sum[MAG_W-1] ? MAG_W'(-sum) : sum;
         end
         // energy step: square, then two weight partial products, added into the saturating energy
         ST_E0: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         ST_E1: begin
            mul_a    = mul_prod[MAG_W-1:0];
            mul_b    = {1'b0, weight_ff};
            sq_hi_in = mul_prod[PROD_W-1:MAG_W];
         end
         ST_E2: begin
            mul_a   = sq_hi_ff;
            mul_b   = {1'b0, weight_ff};
            mul_ctl = '{acc_op: ACC_LOAD, shift: SH_0};
         end
         ST_E3: begin
            mul_ctl = '{acc_op: ACC_ADD, shift: SH_17};
         end
         ST_E4: begin
            energy_in = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
         end
         // pulse width: duty times energy in two halves, rounded and clamped to the pulse span
         ST_W0: begin
            mul_a = {1'b0, energy_ff[HALF_W-1:0]};
            mul_b = {1'b0, duty_ff};
         end
         ST_W1: begin
            mul_a   = {1'b0, energy_ff[ENERGY_W-1:HALF_W]};
            mul_b   = {1'b0, duty_ff};
            mul_ctl = '{acc_op: ACC_LOAD, shift: SH_0};
         end
         ST_W2: begin
            mul_ctl = '{acc_op: ACC_ADD, shift: SH_16};
         end
         ST_W3: begin
            wraw_in = round_sum[DPROD_W:WIDTH_SHIFT];
         end
         ST_W4: begin
            span_in  = position_ff - POS_W'(start_ff);
            width_in = (wraw_ff > WRAW_W'(span_in)) ? span_in : POS_W'(wraw_ff);
         end
         ST_W5: begin
            fill_addr_in = first[ADDR_W-1:0];
            fill_cnt_in  = width_ff;
         end
         // write the centred run of the sign
         ST_FILL: begin
            ram_we       = 1'b1;
            ram_waddr    = fill_addr_ff;
            ram_wdata    = sign_ff;
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            fill_cnt_in  = fill_cnt_ff - POS_W'(1);
         end
         // update the pulse tracking state
         ST_COMMIT: begin
            case (cmd_ff)
               CMD_PUSH: begin
                  if (sgn_now == SIGN_NONE) begin
                     if (sign_ff != SIGN_NONE) begin
                        sign_in   = SIGN_NONE;
                        start_in  = position_ff[ADDR_W-1:0];
                        energy_in = '0;
                     end
                  end else if (sign_ff != sgn_now) begin
                     sign_in   = sgn_now;
                     start_in  = position_ff[ADDR_W-1:0];
                     energy_in = '0;
                  end
                  prev_in     = sample_ff;
                  position_in = position_ff + POS_W'(1);
               end
               CMD_FINISH: begin
                  position_in = '0;
                  start_in    = '0;
                  sign_in     = SIGN_NONE;
                  prev_in     = '0;
                  energy_in   = '0;
               end
               default: begin
                  position_in = position_ff;
               end
            endcase
         end
         ST_READ_OUT: begin
            rsp_valid     = 1'b1;
            rsp_out_value = rd_oor ? $signed(SIGN_NONE) : $signed(ram_rdata);
         end
         default: begin
            mul_ctl = '{acc_op: ACC_HOLD, shift: SH_0};
         end
      endcase
   end

   // register writes
   assign weight_in = (csr_wr_en && csr_index == CSR_WEIGHT) ? csr_wdata : weight_ff;
   assign duty_in   = (csr_wr_en && csr_index == CSR_DUTY) ? csr_wdata : duty_ff;

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         position_ff <= '0;
         start_ff    <= '0;
         sign_ff     <= SIGN_NONE;
         prev_ff     <= '0;
         energy_ff   <= '0;
         weight_ff   <= WEIGHT_RESET;
         duty_ff     <= DUTY_RESET;
      end else begin
         state_ff    <= state_in;
         position_ff <= position_in;
         start_ff    <= start_in;
         sign_ff     <= sign_in;
         prev_ff     <= prev_in;
         energy_ff   <= energy_in;
         weight_ff   <= weight_in;
         duty_ff     <= duty_in;
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         sample_ff <= req_sample_value;
         idx_ff    <= req_read_index;
      end
      mag_ff       <= mag_in;
      sq_hi_ff     <= sq_hi_in;
      wraw_ff      <= wraw_in;
      span_ff      <= span_in;
      width_ff     <= width_in;
      fill_addr_ff <= fill_addr_in;
      fill_cnt_ff  <= fill_cnt_in;
   end

   pwa_mul_unit u_mul (
      .clock (clock),
      .ctl   (mul_ctl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod),
      .acc   (mul_acc)
   );

   pwa_ram #(
      .WIDTH (OUT_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // one result per read request
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DECODE && cmd_ff == CMD_READ)
      else $error("result without a read request");

   // pulse writes stay inside the samples already pushed
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> ({1'b0, fill_addr_ff} < position_ff) && fill_cnt_ff != '0)
      else $error("pulse write outside the column");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_W'(MAX_SAMPLES))
      else $error("position beyond column size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted without going busy");

endmodule

`default_nettype wire

// ===== tb/pwa_checker.sv =====
// checker for the pulse width apodizer: tracks its state, predicts read values, compares
`timescale 1ns / 100ps

module pwa_checker import pwa_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic        [CMD_W-1:0]     req_cmd,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_value,
   input  wire logic        [IDX_W-1:0]     req_read_index,
   input  wire logic                        rsp_valid,
   input  wire logic signed [OUT_W-1:0]     rsp_out_value,
   input  wire logic                        csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [CFG_W-1:0]     csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);

   // predicted column state
   logic [OUT_W-1:0]           trinary_image [MAX_SAMPLES];
   int unsigned                col_pos;
   int unsigned                pulse_first;
   logic [OUT_W-1:0]           pulse_sgn;
   logic signed [SAMPLE_W-1:0] last_sample;
   logic [ENERGY_W-1:0]        energy;
   logic [CFG_W-1:0]           weight;
   logic [CFG_W-1:0]           duty;

   // read values still owed by the block, oldest first
   logic [OUT_W-1:0]           owed_reads [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // write the centred run of sign copies for the pulse ending at stop
   task automatic close_pulse(input int unsigned stop);
      int unsigned span;
      int unsigned width;
      int unsigned first;
      logic [63:0] scaled;
      if (pulse_sgn == SIGN_NONE || stop < pulse_first) return;
      span   = stop - pulse_first;
      scaled = (64'(duty) * 64'(energy) + (64'd1 << (WIDTH_SHIFT - 1))) >> WIDTH_SHIFT;
      width  = (scaled > 64'(span)) ? span : scaled[31:0];
      first  = pulse_first + ((span - width) >> 1);
      for (int unsigned k = 0; k < width; k++) begin
         if (first + k < MAX_SAMPLES) trinary_image[first + k] = pulse_sgn;
      end
   endtask

   // one pushed sample: clear its slot, then open, extend or close a pulse
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      logic [OUT_W-1:0]        sgn;
      logic signed [MAG_W-1:0] sum;
      logic [MAG_W-1:0]        mag;
      logic [63:0]             term;
      logic [63:0]             acc;
      if (col_pos >= MAX_SAMPLES) return;
      trinary_image[col_pos] = SIGN_NONE;
      sgn = (s > 0) ? SIGN_POS : ((s < 0) ? SIGN_NEG : SIGN_NONE);
      if (sgn == SIGN_NONE) begin
         if (pulse_sgn != SIGN_NONE) begin
            close_pulse(col_pos);
            pulse_sgn   = SIGN_NONE;
            pulse_first = col_pos;
            energy      = '0;
         end
      end else if (pulse_sgn != sgn) begin
         if (pulse_sgn != SIGN_NONE) close_pulse(col_pos);
         pulse_sgn   = sgn;
         pulse_first = col_pos;
         energy      = '0;
      end else begin
         sum    = {last_sample[SAMPLE_W-1], last_sample} + {s[SAMPLE_W-1], s};
         mag    = sum[MAG_W-1] ? -sum : sum;
         term   = (64'(mag) * 64'(mag) * 64'(weight)) >> TERM_SHIFT;
         acc    = 64'(energy) + term;
         energy = (acc > 64'hFFFF_FFFF) ? '1 : acc[ENERGY_W-1:0];
      end
      last_sample = s;
      col_pos++;
   endtask

   // end of column: close the open pulse and rewind, the image stays
   task automatic finish_column();
      close_pulse(col_pos);
      col_pos     = 0;
      pulse_first = 0;
      pulse_sgn   = SIGN_NONE;
      last_sample = '0;
      energy      = '0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (trinary_image[i]) trinary_image[i] = SIGN_NONE;
         col_pos     = 0;
         pulse_first = 0;
         pulse_sgn   = SIGN_NONE;
         last_sample = '0;
         energy      = '0;
         weight      = WEIGHT_RESET;
         duty        = DUTY_RESET;
         owed_reads.delete();
      end else begin
         // response check against the oldest owed read
         if (rsp_valid) begin
            if (owed_reads.size() == 0) begin
               report_mismatch($sformatf("response %0d with no read pending",
                                         rsp_out_value));
            end else if (rsp_out_value !== $signed(owed_reads[0])) begin
               report_mismatch($sformatf("read value %0d, predicted %0d",
                                         rsp_out_value, $signed(owed_reads[0])));
               void'(owed_reads.pop_front());
            end else begin
               void'(owed_reads.pop_front());
            end
         end

         // register writes
         if (csr_wr_en) begin
            if (csr_index == CSR_WEIGHT) weight = csr_wdata;
            else duty = csr_wdata;
         end

         // accepted request
         if (start && !busy) begin
            case (req_cmd)
               CMD_PUSH:   push_sample(req_sample_value);
               CMD_FINISH: finish_column();
               CMD_READ:   owed_reads.push_back(trinary_image[req_read_index]);
               default: ;
            endcase
         end
      end
      pending_count = owed_reads.size();
   end

endmodule

// ===== tb/pulse_width_apodizer_top_test.sv =====
// testbench top for the pulse width apodizer: stimulus, run limit and verdict
`timescale 1ns / 100ps

module pulse_width_apodizer_top_test import pwa_pkg::*;;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 140;

   // block ports
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic        [CMD_W-1:0]     req_cmd = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_value = '0;
   logic        [IDX_W-1:0]     req_read_index = '0;
   logic                        rsp_valid;
   logic signed [OUT_W-1:0]     rsp_out_value;
   logic                        csr_wr_en = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index = '0;
   logic        [CFG_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending_count;

   // stimulus bookkeeping
   int          cycle_count = 0;
   int unsigned idle_pct = 0;
   int unsigned item_count = 0;
   int unsigned col_fill = 0;
   int unsigned written_top = 0;

   pulse_width_apodizer_top i_dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_sample_value, .req_read_index,
      .rsp_valid, .rsp_out_value,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   pwa_checker i_checker (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_sample_value, .req_read_index,
      .rsp_valid, .rsp_out_value,
      .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request: optional hold-off, random idle, then wait for the handshake
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [SAMPLE_W-1:0] sample,
                               input logic [IDX_W-1:0] index);
      bit pause;
      pause = ($urandom_range(59) == 0);
      while ((pause && pending_count != 0) ||
             (idle_pct != 0 && $urandom_range(99) < idle_pct)) begin
         start            <= 1'b0;
         req_cmd          <= CMD_W'($urandom);
         req_sample_value <= SAMPLE_W'($urandom);
         req_read_index   <= IDX_W'($urandom);
         @(negedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_sample_value <= sample;
      req_read_index   <= index;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (cmd == CMD_PUSH && col_fill < MAX_SAMPLES) begin
         col_fill++;
         if (col_fill > written_top) written_top = col_fill;
      end else if (cmd == CMD_FINISH) begin
         col_fill = 0;
      end
      item_count++;
   endtask

   // reads only ever target positions written since reset
   task automatic read_written();
      send_request(CMD_READ, SAMPLE_W'($urandom), IDX_W'($urandom_range(written_top - 1)));
   endtask

   // both registers, back to back, while the block is idle
   task automatic write_settings(input logic [CFG_W-1:0] weight,
                                 input logic [CFG_W-1:0] duty);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WEIGHT;
      csr_wdata <= weight;
      @(negedge clock);
      csr_index <= CSR_DUTY;
      csr_wdata <= duty;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly large magnitudes so pulses gain visible width
   function automatic logic signed [SAMPLE_W-1:0] pulse_sample(input bit negative);
      int unsigned r;
      int unsigned mag;
      logic signed [SAMPLE_W-1:0] v;
      r = $urandom_range(99);
      if (r < 60) mag = $urandom_range(32767, 16384);
      else if (r < 80) mag = $urandom_range(32767, 1);
      else mag = $urandom_range(255, 1);
      v = mag[SAMPLE_W-1:0];
      if (negative && $urandom_range(19) == 0) return 16'sh8000;
      return negative ? -v : v;
   endfunction

   // a column of pulse runs with some noise, then finish and read back
   task automatic random_column(input int unsigned len);
      int unsigned pushed;
      int unsigned run;
      int unsigned r;
      bit negative;
      pushed = 0;
      while (pushed < len) begin
         r = $urandom_range(99);
         if (r < 70) begin
            negative = ($urandom_range(1) != 0);
            run = $urandom_range(10, 1);
            repeat (run) send_request(CMD_PUSH, pulse_sample(negative), IDX_W'($urandom));
            pushed += run;
            if ($urandom_range(1) != 0) begin
               send_request(CMD_PUSH, '0, IDX_W'($urandom));
               pushed++;
            end
         end else if (r < 80) begin
            read_written();
         end else if (r < 85) begin
            send_request(CMD_NOP, SAMPLE_W'($urandom), IDX_W'($urandom));
         end else if (r < 92) begin
            send_request(CMD_PUSH, SAMPLE_W'($urandom), IDX_W'($urandom));
            pushed++;
         end else begin
            send_request(CMD_PUSH, '0, IDX_W'($urandom));
            pushed++;
         end
      end
      send_request(CMD_FINISH, SAMPLE_W'($urandom), IDX_W'($urandom));
      repeat ($urandom_range(4, 1)) read_written();
   endtask

   task automatic run_phase(input int unsigned pct, input logic [CFG_W-1:0] weight,
                            input logic [CFG_W-1:0] duty);
      int unsigned first_item;
      wait_until_idle();
      write_settings(weight, duty);
      idle_pct = pct;
      first_item = item_count;
      while (item_count - first_item < PHASE_ITEMS) begin
         random_column(($urandom_range(7) == 0) ? $urandom_range(120, 41)
                                                : $urandom_range(40, 1));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_settings(WEIGHT_RESET, DUTY_RESET);
      idle_pct = 21;

      // directed: full-scale pulse, sign change, zero end, tiny samples,
      // unused command, pulse closed by finish, empty finish
      send_request(CMD_PUSH, 16'sd32767, '0);
      send_request(CMD_PUSH, 16'sd32767, '1);
      send_request(CMD_PUSH, 16'sd32767, '0);
      send_request(CMD_PUSH, 16'sh8000, '1);
      send_request(CMD_PUSH, 16'sh8000, '0);
      send_request(CMD_PUSH, -16'sd32767, '1);
      send_request(CMD_PUSH, 16'sd0, '0);
      send_request(CMD_PUSH, 16'sd0, '1);
      send_request(CMD_PUSH, 16'sd1, '0);
      send_request(CMD_PUSH, -16'sd1, '1);
      send_request(CMD_PUSH, 16'sd32767, '0);
      send_request(CMD_PUSH, 16'sd32767, '1);
      send_request(CMD_NOP, '1, '1);
      send_request(CMD_FINISH, '0, '0);
      for (int k = 0; k < 12; k++) send_request(CMD_READ, '1, IDX_W'(k));
      send_request(CMD_FINISH, '1, '1);

      // a column that overruns the store, then the last position
      random_column(MAX_SAMPLES + 6);
      send_request(CMD_READ, '0, '1);

      // register settings, extremes among them
      run_phase(21, 16'd0, 16'hFFFF);
      run_phase(59, CFG_W'($urandom_range(32768)), CFG_W'($urandom));
      run_phase(59, 16'd32768, 16'hFFFF);
      run_phase(0, 16'd1, CFG_W'($urandom));
      run_phase(0, CFG_W'($urandom_range(32768)), 16'd0);

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== pulse_width_apodizer_top.f =====
rtl/pwa_pkg.sv
rtl/pwa_ram.sv
rtl/pwa_mul_unit.sv
rtl/pulse_width_apodizer_top.sv
tb/pwa_checker.sv
tb/pulse_width_apodizer_top_test.sv
